// File: hdl/bspc_pkg.sv
// ----------------------------------------------------------------------------
// bspc_pkg
// Shared codes and controller/datapath bundles for the bounded stack core.
// ----------------------------------------------------------------------------
package bspc_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 4;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_RD,
		S_PAL,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic pop_cap;
		logic pal_start;
		logic pal_run;
		logic pal_cap;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic pal_done;
	} stat_t;

endpackage

// File: hdl/bspc_req_if.sv
// ----------------------------------------------------------------------------
// bspc_req_if
// Request channel: one stack operation and its operand word.
// ----------------------------------------------------------------------------
interface bspc_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  mode;
	logic signed [31:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: hdl/bspc_rsp_if.sv
// ----------------------------------------------------------------------------
// bspc_rsp_if
// Response channel: status, popped word, palindrome flag and entry count.
// ----------------------------------------------------------------------------
interface bspc_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] popped_value;
	logic               is_palindrome;
	logic        [3:0]  entry_count;

	modport source (output valid, output status, output popped_value,
		output is_palindrome, output entry_count, input ready);
	modport sink   (input valid, input status, input popped_value,
		input is_palindrome, input entry_count, output ready);
endinterface

// File: hdl/bspc_ram.sv
// ----------------------------------------------------------------------------
// bspc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bspc_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_a,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: hdl/bspc_datapath.sv
// ----------------------------------------------------------------------------
// bspc_datapath
// Entry count, stack RAM, palindrome walk and result/output registers.
// ----------------------------------------------------------------------------
module bspc_datapath #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bspc_pkg::cmd_t       cmd,
	output bspc_pkg::stat_t      stat,
	input  logic [1:0]           mode,
	input  logic signed [31:0]   value,
	output logic [1:0]           status,
	output logic signed [31:0]   popped_value,
	output logic                 is_palindrome,
	output logic [3:0]           entry_count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 lo_q, hi_q;
	logic                          pal_ok_q;
	logic                          cmp_vld_s1;
	logic [1:0]                    res_status_q;
	logic [bspc_pkg::WORD_W-1:0]   res_popped_q;
	logic                          res_pal_q;

	logic                          full, empty, more, issue, push_ok, pop_ok;
	logic [1:0]                    status_d;
	logic [AW-1:0]                 top_addr, raddr_a;
	logic [bspc_pkg::WORD_W-1:0]   rd_a, rd_b;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign more     = (lo_q < hi_q);
	assign issue    = cmd.pal_run && more;
	assign push_ok  = cmd.accept && (mode == bspc_pkg::MODE_PUSH) && !full;
	assign pop_ok   = cmd.accept && (mode == bspc_pkg::MODE_POP) && !empty;
	assign top_addr = AW'(count_q - CW'(1));
	assign raddr_a  = cmd.pal_run ? lo_q : top_addr;

	// pal_done is only looked at while the walk runs
	assign stat.empty    = empty;
	assign stat.pal_done = !more && !cmp_vld_s1;

	always_comb begin
		case (mode)
			bspc_pkg::MODE_PUSH:  status_d = full  ? bspc_pkg::ST_OVERFLOW : bspc_pkg::ST_OK;
			bspc_pkg::MODE_POP:   status_d = empty ? bspc_pkg::ST_EMPTY : bspc_pkg::ST_OK;
			bspc_pkg::MODE_QUERY: status_d = empty ? bspc_pkg::ST_EMPTY : bspc_pkg::ST_OK;
			default:              status_d = bspc_pkg::ST_OK;
		endcase
	end

	bspc_ram #(
		.WIDTH (bspc_pkg::WORD_W),
		.DEPTH (DEPTH),
		.ADDR_W(AW)
	) u_ram (
		.clk    (clk),
		.we     (push_ok),
		.waddr  (AW'(count_q)),
		.wdata  (value),
		.raddr_a(raddr_a),
		.raddr_b(hi_q),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (push_ok) begin
				count_q <= count_q + CW'(1);
			end else if (pop_ok) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_start) begin
			lo_q     <= '0;
			hi_q     <= top_addr;
			pal_ok_q <= 1'b1;
		end else begin
			if (issue) begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			if (cmp_vld_s1 && (rd_a != rd_b)) begin
				pal_ok_q <= 1'b0;
			end
		end

		if (cmd.accept) begin
			res_status_q <= status_d;
			res_popped_q <= '0;
			res_pal_q    <= 1'b0;
		end
		if (cmd.pop_cap) begin
			res_popped_q <= rd_a;
		end
		if (cmd.pal_cap) begin
			res_pal_q <= pal_ok_q;
		end

		if (cmd.load_out) begin
			status        <= res_status_q;
			popped_value  <= res_popped_q;
			is_palindrome <= res_pal_q;
			entry_count   <= bspc_pkg::COUNT_W'(count_q);
		end
	end

endmodule

// File: hdl/bspc_ctrl.sv
// ----------------------------------------------------------------------------
// bspc_ctrl
// Sequencer: accepts a request, steps the datapath, hands off the response.
// ----------------------------------------------------------------------------
module bspc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       mode,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  bspc_pkg::stat_t  stat,
	output bspc_pkg::cmd_t   cmd
);

	bspc_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bspc_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			bspc_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = bspc_pkg::S_FINISH;
					if ((mode == bspc_pkg::MODE_POP) && !stat.empty) begin
						state_d = bspc_pkg::S_POP_RD;
					end else if ((mode == bspc_pkg::MODE_QUERY) && !stat.empty) begin
						cmd.pal_start = 1'b1;
						state_d       = bspc_pkg::S_PAL;
					end
				end
			end
			bspc_pkg::S_POP_RD: begin
				cmd.pop_cap = 1'b1;
				state_d     = bspc_pkg::S_FINISH;
			end
			bspc_pkg::S_PAL: begin
				cmd.pal_run = 1'b1;
				if (stat.pal_done) begin
					cmd.pal_cap = 1'b1;
					state_d     = bspc_pkg::S_FINISH;
				end
			end
			bspc_pkg::S_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = bspc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bspc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/bounded_stack_with_palindrome_check_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_palindrome_check_core
// LIFO stack of DEPTH signed 32-bit words with push, pop and palindrome query.
// ----------------------------------------------------------------------------
// Each request carries a mode (0 push, 1 pop, 2 palindrome query, 3 no
// operation) and a word; each request yields exactly one response with a
// status (0 ok, 1 overflow, 2 underflow or empty), the popped word (zero
// unless a pop succeeded), the palindrome flag and the low four bits of the
// entry count after the operation. A push onto a full stack and a pop from
// an empty one leave the stack as it is. One request is in flight at a time.
// Push, no-op and a query on an empty stack go from acceptance straight to
// the state that loads the response; a pop first takes one registered read
// of the stack RAM, and a query on one or more entries first runs the walk,
// which reads one mirrored pair per cycle through the two RAM read ports,
// compares it in the cycle after the read, and captures the flag in the
// cycle after the last compare. The response sits in an output register,
// so the next request is taken while the previous response still waits for
// rsp.ready. The stack RAM needs no clearing after reset; entries are read
// only after being pushed.
module bounded_stack_with_palindrome_check_core #(
	parameter int unsigned DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bspc_req_if.sink   req,
	bspc_rsp_if.source rsp
);

	bspc_pkg::cmd_t  cmd;
	bspc_pkg::stat_t stat;

	// Sequencer: owns the handshakes and the output valid flag.
	bspc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.mode     (req.mode),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: count, storage, mirror compare and the response payload.
	bspc_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (req.mode),
		.value        (req.value),
		.status       (rsp.status),
		.popped_value (rsp.popped_value),
		.is_palindrome(rsp.is_palindrome),
		.entry_count  (rsp.entry_count)
	);

endmodule

// File: bench/tb_bounded_stack_with_palindrome_check_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_palindrome_check_core
// Self-checking bench for the bounded stack with palindrome query.
// ----------------------------------------------------------------------------
// Drives stack requests over a valid/ready channel and predicts every response
// with a behavioral stack kept in step with each accepted request. Directed
// corners come first: underflow and empty query, overflow, the no-op mode, a
// single entry, a full symmetric stack, an odd-depth asymmetric stack and the extreme words.
// Then come back-pressure and drain phases, a stretch with no idling, and
// random sequences that build mirrored stacks (some with one corrupted bit)
// and query them. Random gaps and stalls are applied on both sides.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_palindrome_check_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STACK_DEPTH = 8;
	localparam int unsigned RANDOM_REQUESTS = 1900;
	// Cycles with no handshake on either side before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_OFF_CYCLES = 150;

	// Mode 3 has no name in the package; the block treats it as a no-op.
	localparam logic [1:0] MODE_NOP = 2'd3;

	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] WORD_ALL_ONES = -32'sd1;

	typedef struct {
		bspc_pkg::status_t  status;
		logic signed [31:0] popped_value;
		logic               is_palindrome;
		logic        [3:0]  entry_count;
	} stack_result_t;

	logic clk;
	logic arst_n;

	bspc_req_if req_ch ();
	bspc_rsp_if rsp_ch ();

	bounded_stack_with_palindrome_check_core #(
		.DEPTH(STACK_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow of the stack contents, advanced on every accepted request.
	logic signed [31:0] shadow_words [STACK_DEPTH];
	int unsigned        shadow_fill;

	stack_result_t responses_due [$];

	int unsigned mismatches;
	int unsigned requests_sent;

	// Idling knobs, flipped by the test tasks.
	bit sender_gaps;
	bit receiver_stalls;

	// Hold-off request from a test; the receiver process counts it down.
	int unsigned hold_request;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Apply one operation to the shadow stack and return the response it owes.
	function automatic stack_result_t apply_stack_op(logic [1:0] op, logic signed [31:0] word);
		stack_result_t res;
		int unsigned   lo;
		int unsigned   hi;
		res.status        = bspc_pkg::ST_OK;
		res.popped_value  = '0;
		res.is_palindrome = 1'b0;
		case (op)
			bspc_pkg::MODE_PUSH: begin
				if (shadow_fill >= STACK_DEPTH) begin
					// full: report overflow, leave contents alone
					res.status = bspc_pkg::ST_OVERFLOW;
				end else begin
					shadow_words[shadow_fill] = word;
					shadow_fill++;
				end
			end
			bspc_pkg::MODE_POP: begin
				if (shadow_fill == 0) begin
					res.status = bspc_pkg::ST_EMPTY;
				end else begin
					shadow_fill--;
					res.popped_value = shadow_words[shadow_fill];
				end
			end
			bspc_pkg::MODE_QUERY: begin
				if (shadow_fill == 0) begin
					res.status = bspc_pkg::ST_EMPTY;
				end else begin
					// walk mirrored pairs inward; a lone entry is symmetric
					res.is_palindrome = 1'b1;
					lo = 0;
					hi = shadow_fill - 1;
					while (lo < hi) begin
						if (shadow_words[lo] != shadow_words[hi])
							res.is_palindrome = 1'b0;
						lo++;
						hi--;
					end
				end
			end
			default: ;  // no-op: plain ok with the count unchanged
		endcase
		res.entry_count = 4'(shadow_fill);
		return res;
	endfunction

	// Bias toward extremes and small values so mirrored pairs collide often.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return WORD_ALL_ONES;
			3:       return '0;
			4, 5:    return 32'($urandom_range(0, 3));
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offer one request and hold it until accepted. Valid stays high on return
	// so back-to-back requests need no extra assignment in the same step.
	task automatic send_request(input logic [1:0] op, input logic signed [31:0] word);
		while (sender_gaps && $urandom_range(0, 99) < 17) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= op;
		req_ch.value <= word;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		responses_due.push_back(apply_stack_op(op, word));
		requests_sent++;
	endtask

	// Drop valid and wait until every owed response has been taken.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (responses_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: stall at random, honor hold-offs, check each response
	// ------------------------------------------------------------------------

	initial begin
		stack_result_t want;
		rsp_ch.ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (responses_due.size() == 0) begin
					mismatches++;
					$display("%0t: response with nothing owed: status %0d popped %0d pal %0b count %0d",
						$time, rsp_ch.status, rsp_ch.popped_value, rsp_ch.is_palindrome,
						rsp_ch.entry_count);
				end else begin
					want = responses_due.pop_front();
					if (rsp_ch.status !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp_ch.status);
					end
					if (rsp_ch.popped_value !== want.popped_value) begin
						mismatches++;
						$display("%0t: popped_value expected %0d actual %0d",
							$time, want.popped_value, rsp_ch.popped_value);
					end
					if (rsp_ch.is_palindrome !== want.is_palindrome) begin
						mismatches++;
						$display("%0t: is_palindrome expected %0b actual %0b",
							$time, want.is_palindrome, rsp_ch.is_palindrome);
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						mismatches++;
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, rsp_ch.entry_count);
					end
				end
			end
			// pick up a fresh hold-off, then decide ready for the next cycle
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= !(receiver_stalls && $urandom_range(0, 99) < 17);
			end
		end
	end

	// Watchdog: count cycles in which neither side hands anything over.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Hit each corner once: empty stack, single entry, extremes, full stack.
	task automatic test_directed_corners();
		logic signed [31:0] mirror [STACK_DEPTH];
		mirror = '{WORD_ALL_ONES, '0, WORD_MIN, WORD_MAX,
			WORD_MAX, WORD_MIN, '0, WORD_ALL_ONES};
		send_request(bspc_pkg::MODE_POP, WORD_MAX);     // underflow
		send_request(bspc_pkg::MODE_QUERY, WORD_MIN);   // query on empty
		send_request(MODE_NOP, WORD_ALL_ONES);          // no-op on empty
		send_request(bspc_pkg::MODE_PUSH, WORD_MIN);
		send_request(bspc_pkg::MODE_QUERY, '0);         // one entry reads as symmetric
		send_request(bspc_pkg::MODE_PUSH, WORD_MAX);
		send_request(bspc_pkg::MODE_QUERY, '0);         // two unequal entries
		send_request(bspc_pkg::MODE_POP, '0);
		send_request(bspc_pkg::MODE_POP, '0);
		foreach (mirror[i])
			send_request(bspc_pkg::MODE_PUSH, mirror[i]);
		send_request(bspc_pkg::MODE_QUERY, '0);         // full, symmetric
		send_request(bspc_pkg::MODE_PUSH, 32'sd5);      // overflow
		send_request(MODE_NOP, WORD_MAX);               // no-op on full
		send_request(bspc_pkg::MODE_POP, WORD_MIN);
		send_request(bspc_pkg::MODE_QUERY, '0);         // odd depth, not symmetric
	endtask

	// Hold the receiver off while requests keep coming so the block backs up.
	task automatic test_backpressure_fill();
		hold_request = HOLD_OFF_CYCLES;
		repeat (10)
			send_request(bspc_pkg::MODE_PUSH, pick_word());
		repeat (10)
			send_request(bspc_pkg::MODE_POP, pick_word());
		send_request(bspc_pkg::MODE_QUERY, '0);
	endtask

	// Let the block go fully idle between bursts.
	task automatic test_sender_pause();
		repeat (3) begin
			repeat ($urandom_range(2, 6))
				send_request(2'($urandom_range(0, 3)), pick_word());
			drain_responses();
		end
	endtask

	// Build a stack that is mirrored, or nearly so, then query and unwind it.
	task automatic run_mirror_sequence();
		logic signed [31:0] seq_words [STACK_DEPTH];
		int unsigned        len;
		int unsigned        spot;
		int unsigned        bit_pos;
		while (shadow_fill != 0)
			send_request(bspc_pkg::MODE_POP, pick_word());
		len = $urandom_range(1, STACK_DEPTH);
		for (int unsigned i = 0; i < len; i++)
			seq_words[i] = (i < (len + 1) / 2) ? pick_word() : seq_words[len - 1 - i];
		// corrupt one bit now and then so the mismatch path gets exercised
		if ($urandom_range(0, 2) == 0) begin
			spot    = $urandom_range(0, len - 1);
			bit_pos = $urandom_range(0, 31);
			seq_words[spot][bit_pos] = ~seq_words[spot][bit_pos];
		end
		for (int unsigned i = 0; i < len; i++) begin
			send_request(bspc_pkg::MODE_PUSH, seq_words[i]);
			if ($urandom_range(0, 3) == 0)
				send_request(bspc_pkg::MODE_QUERY, pick_word());
		end
		send_request(bspc_pkg::MODE_QUERY, pick_word());
		if ($urandom_range(0, 3) == 0) begin
			// top up past full to provoke overflow
			repeat (STACK_DEPTH - shadow_fill + 1)
				send_request(bspc_pkg::MODE_PUSH, pick_word());
			send_request(bspc_pkg::MODE_QUERY, '0);
		end
		repeat ($urandom_range(0, len + 1)) begin
			send_request(bspc_pkg::MODE_POP, pick_word());
			if ($urandom_range(0, 2) == 0)
				send_request(bspc_pkg::MODE_QUERY, pick_word());
		end
	endtask

	// Mostly mirrored sequences, with bursts of raw noise in between.
	task automatic test_random_sequences(input int unsigned count);
		int unsigned stop_at;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_request(2'($urandom_range(0, 3)), $urandom());
			end else begin
				run_mirror_sequence();
			end
		end
	endtask

	// Full throughput on both sides.
	task automatic test_no_idling();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		test_random_sequences(300);
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.mode     = bspc_pkg::MODE_PUSH;
		req_ch.value    = '0;
		arst_n          = 1'b0;
		shadow_fill     = 0;
		mismatches      = 0;
		requests_sent   = 0;
		hold_request    = 0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_backpressure_fill();
		test_sender_pause();
		test_no_idling();
		test_random_sequences(RANDOM_REQUESTS - requests_sent);

		drain_responses();
		// a query walk is the longest thing that can still be in flight
		repeat (STACK_DEPTH + 20) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
